// ===== hw/rtl/fir_pkg.sv =====
// ----------------------------------------------------------------------------
// FIR filter package
// Shared sizes, codes and types for the direct-form FIR filter core.
// ----------------------------------------------------------------------------
`default_nettype none

package fir_pkg;

   localparam int TAPS    = 8;
   localparam int DATA_W  = 16;
   localparam int PROD_W  = 2 * DATA_W;
   localparam int ACC_W   = PROD_W + $clog2(TAPS) + 1;
   localparam int CNT_W   = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int FRAC_W  = DATA_W - 1;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_COEF   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_DONE
   } fsm_state_type;

   typedef struct packed {
      logic shift_en;
      logic mul_en;
      logic coef_we;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/fir_filter_direct_form_core.sv =====
// ----------------------------------------------------------------------------
// Direct-form FIR filter core
// Eight-tap FIR filter built from a chain of tap cells, with a Q1.15 output
// that is rounded half up and saturated.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the req_ channel (valid/ready). A request with req_cmd
// set writes req_tap_value into coefficient req_tap_index and gives no
// response. A request with req_cmd clear shifts req_sample_in into the
// delay line and later gives one response on the rsp_ channel:
// rsp_filtered and rsp_clipped.
// After a sample request is accepted, the products are registered in every
// cell, the partial sum ripples down the cell chain, and the sum is rounded
// and loaded into the output register, which makes the response valid;
// req_ready returns together with it.
// The output register lets a new request be taken while a response waits.
// If the receiver stalls, a finished sum is held until the output register
// frees up, and no new request is taken in the meantime.
// Reset clears the delay line, the coefficients and all control state.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_filter_direct_form_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_cmd,
   input  wire logic signed [fir_pkg::DATA_W-1:0]  req_sample_in,
   input  wire logic [2:0]                         req_tap_index,
   input  wire logic signed [fir_pkg::DATA_W-1:0]  req_tap_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [fir_pkg::DATA_W-1:0]       rsp_filtered,
   output logic                                    rsp_clipped
);

   localparam logic signed [fir_pkg::ACC_W-1:0] RND   = fir_pkg::ACC_W'(1 << (fir_pkg::FRAC_W - 1));
   localparam logic signed [fir_pkg::ACC_W-1:0] Q_MAX = fir_pkg::ACC_W'(32767);
   localparam logic signed [fir_pkg::ACC_W-1:0] Q_MIN = -fir_pkg::ACC_W'(32768);

   fir_pkg::fsm_state_type           st_ff, st_in;
   logic [fir_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [fir_pkg::DATA_W-1:0] rsp_filtered_ff;
   logic                             rsp_clipped_ff;
   logic                             load_out;

   logic                             accept;
   logic                             shift_en;
   logic                             mul_en;
   logic                             coef_wr;

   logic signed [fir_pkg::DATA_W-1:0] sample_chain [fir_pkg::TAPS+1];
   logic signed [fir_pkg::ACC_W-1:0]  sum_chain [fir_pkg::TAPS+1];

   logic signed [fir_pkg::ACC_W-1:0]  rounded;
   logic signed [fir_pkg::ACC_W-1:0]  quot;
   logic signed [fir_pkg::DATA_W-1:0] sat_value;
   logic                              sat_flag;

   assign accept  = req_valid && req_ready;
   assign shift_en = accept && (req_cmd == fir_pkg::CMD_SAMPLE);
   assign coef_wr  = accept && (req_cmd == fir_pkg::CMD_COEF);

   assign sample_chain[0] = req_sample_in;
   assign sum_chain[0]    = '0;

   for (genvar i = 0; i < fir_pkg::TAPS; i++) begin : g_cell
      fir_pkg::cell_ctrl_type ctrl;

      assign ctrl.shift_en = shift_en;
      assign ctrl.mul_en   = mul_en;
      assign ctrl.coef_we  = coef_wr && (int'(req_tap_index) == i);

      fir_tap_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .sample_in  (sample_chain[i]),
         .sample_out (sample_chain[i+1]),
         .tap_value  (req_tap_value),
         .sum_in     (sum_chain[i]),
         .sum_out    (sum_chain[i+1])
      );
   end

   always_comb begin
      rounded = sum_chain[fir_pkg::TAPS] + RND;
      quot    = rounded >>> fir_pkg::FRAC_W;
      if (quot > Q_MAX) begin
         sat_value = fir_pkg::DATA_W'(Q_MAX);
         sat_flag  = 1'b1;
      end else if (quot < Q_MIN) begin
         sat_value = fir_pkg::DATA_W'(Q_MIN);
         sat_flag  = 1'b1;
      end else begin
         sat_value = quot[fir_pkg::DATA_W-1:0];
         sat_flag  = 1'b0;
      end
   end

   always_comb begin
      st_in     = st_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      mul_en    = 1'b0;
      load_out  = 1'b0;
      unique case (st_ff)
         fir_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && (req_cmd == fir_pkg::CMD_SAMPLE)) begin
               st_in = fir_pkg::ST_MUL;
            end
         end
         fir_pkg::ST_MUL: begin
            mul_en = 1'b1;
            cnt_in = '0;
            st_in  = fir_pkg::ST_ACC;
         end
         fir_pkg::ST_ACC: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == fir_pkg::CNT_W'(fir_pkg::TAPS - 1)) begin
               st_in = fir_pkg::ST_DONE;
            end
         end
         fir_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out = 1'b1;
               st_in    = fir_pkg::ST_IDLE;
            end
         end
         default: begin
            st_in = fir_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= fir_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_filtered_ff <= sat_value;
         rsp_clipped_ff  <= sat_flag;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;
   assign rsp_clipped  = rsp_clipped_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/fir_tap_cell.sv =====
// ----------------------------------------------------------------------------
// FIR tap cell
// Holds one delay-line sample and one coefficient, forms their product and
// adds it to the partial sum handed over from the neighboring cell.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_tap_cell (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire fir_pkg::cell_ctrl_type              ctrl,
   input  wire logic signed [fir_pkg::DATA_W-1:0]   sample_in,
   output logic signed [fir_pkg::DATA_W-1:0]        sample_out,
   input  wire logic signed [fir_pkg::DATA_W-1:0]   tap_value,
   input  wire logic signed [fir_pkg::ACC_W-1:0]    sum_in,
   output logic signed [fir_pkg::ACC_W-1:0]         sum_out
);

   logic signed [fir_pkg::DATA_W-1:0] sample_ff;
   logic signed [fir_pkg::DATA_W-1:0] tap_ff;
   logic signed [fir_pkg::PROD_W-1:0] prod_ff;
   logic signed [fir_pkg::PROD_W-1:0] prod_in;
   logic signed [fir_pkg::ACC_W-1:0]  sum_ff;
   logic signed [fir_pkg::ACC_W-1:0]  sum_in_next;

   always_comb begin
      prod_in     = sample_ff * tap_ff;
      sum_in_next = sum_in + fir_pkg::ACC_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
         tap_ff    <= '0;
      end else begin
         if (ctrl.shift_en) begin
            sample_ff <= sample_in;
         end
         if (ctrl.coef_we) begin
            tap_ff <= tap_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
      sum_ff <= sum_in_next;
   end

   assign sample_out = sample_ff;
   assign sum_out    = sum_ff;

endmodule

`default_nettype wire
